FILE: hdl/particle_pool_update_core_defines.svh
// Assertion macros for the particle pool core.
// Used by hdl/particle_pool_update_core.sv; no other dependencies.
`ifndef PARTICLE_POOL_UPDATE_CORE_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PPU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PPU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PPU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PPU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/ppu_pkg.sv
// Types and constants of the particle pool core.
// No dependencies.
package ppu_pkg;
  localparam logic [1:0] CMD_EMIT  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;
  localparam int POS_W = 20;
  localparam int VEL_W = 16;
  localparam int LIFE_W = 24;
  localparam int APP_W = 24;
  localparam int CNT_W = 9;
  localparam logic signed [POS_W-1:0] POS_MAX = 20'sh7FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = -20'sh80000;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic [LIFE_W-1:0] life_t;

  // truncation toward zero of Q12.8 to whole cells
  function automatic logic signed [11:0] to_cell(input pos_t p);
    logic signed [11:0] q;
    q = p[19:8];
    if (p[19] && (p[7:0] != 8'd0)) q = q + 12'sd1;
    return q;
  endfunction
endpackage

FILE: hdl/particle_pool_update_core.sv
// Particle pool core: sequencer, per-slot memories and one shared step multiplier.
// Depends on ppu_pkg and particle_pool_update_core_defines.svh.
//
// Usage: drive a command and its fields with start high while busy is low;
// the item is taken at that edge. Exactly one result follows, shown for one
// cycle with out_valid high; the receiver cannot stall it.
// Commands: emit places a particle in the lowest free slot (or in slot mod
// POOL_SIZE when full); tick moves and ages every live particle and recounts;
// read reports one slot; clear kills all.
// Sequence: read passes a memory read and an output state; clear goes straight
// to done; emit searches for a free slot one slot a cycle, then takes slot mod
// POOL_SIZE by repeated subtraction when full; tick passes each slot through the
// single multiplier twice (x then y) in memory read, multiply, and write-back
// steps. busy stays high for the whole command; the next item is taken from
// the cycle the result shows.
// Reset: synchronous, active low; clears live flags and the count at once.
// Positions and appearance are undefined until an emit writes them.
// Life of a dead slot is never read, so it needs no clearing.
`include "particle_pool_update_core_defines.svh"
module particle_pool_update_core #(
  parameter int POOL_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic signed [19:0] in_pos_x,
  input  logic signed [19:0] in_pos_y,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic [7:0]  in_glyph,
  input  logic [7:0]  in_fg_color,
  input  logic [7:0]  in_bg_color,
  input  logic [15:0] in_life_span,
  input  logic [15:0] in_dt,
  input  logic [7:0]  in_slot,
  output logic        out_valid,
  output logic [7:0]  out_slot_used,
  output logic        out_alive,
  output logic signed [11:0] out_cell_x,
  output logic signed [11:0] out_cell_y,
  output logic [7:0]  out_glyph_out,
  output logic [7:0]  out_fg_out,
  output logic [7:0]  out_bg_out,
  output logic [8:0]  out_live_count,
  output logic        out_replaced
);
  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int IW = AW + 1;
  localparam logic [IW-1:0] LAST = IW'(POOL_SIZE - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_EMITW = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_RDOUT = 4'd4;
  localparam logic [3:0] S_TRD   = 4'd5;
  localparam logic [3:0] S_TMX   = 4'd6;
  localparam logic [3:0] S_TMY   = 4'd7;
  localparam logic [3:0] S_TWB   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_MOD   = 4'd10;

  // per-slot storage
  ppu_pkg::pos_t  px_mem [POOL_SIZE];
  ppu_pkg::pos_t  py_mem [POOL_SIZE];
  ppu_pkg::vel_t  vx_mem [POOL_SIZE];
  ppu_pkg::vel_t  vy_mem [POOL_SIZE];
  ppu_pkg::life_t life_mem [POOL_SIZE];
  logic [ppu_pkg::APP_W-1:0] app_mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] live_r, live_nxt;

  logic [3:0] state_r, state_nxt;
  logic [1:0] cmd_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [8:0] cnt_r, cnt_nxt, live_cnt_r, live_cnt_nxt;
  logic [7:0] mod_r, mod_nxt;
  logic [15:0] dt_r;
  logic [7:0] slot_r;
  logic full_r, full_nxt;
  ppu_pkg::pos_t ipx_r, ipy_r;
  ppu_pkg::vel_t ivx_r, ivy_r;
  logic [ppu_pkg::APP_W-1:0] iapp_r;
  logic [15:0] ilife_r;

  // registered memory read data
  ppu_pkg::pos_t  rpx_r, rpy_r;
  ppu_pkg::vel_t  rvx_r, rvy_r;
  ppu_pkg::life_t rlife_r;
  logic [ppu_pkg::APP_W-1:0] rapp_r;
  logic rlive_r;

  // shared step unit: one 16x17 multiply per cycle, then round and saturate
  logic signed [15:0] mv;
  logic signed [16:0] mdt;
  logic signed [32:0] prod;
  ppu_pkg::pos_t mpos, newpos;
  logic signed [21:0] sum;
  ppu_pkg::pos_t nx_r;

  logic [AW-1:0] addr;
  logic ov_valid_r;
  logic [7:0] ov_slot_r, ov_gl_r, ov_fg_r, ov_bg_r;
  logic ov_alive_r, ov_repl_r;
  logic signed [11:0] ov_cx_r, ov_cy_r;

  assign addr = idx_r[AW-1:0];
  assign busy = (state_r != S_IDLE);

  always_comb begin
    mv   = (state_r == S_TMX) ? rvx_r : rvy_r;
    mpos = (state_r == S_TMX) ? rpx_r : rpy_r;
    mdt  = {1'b0, dt_r};
    prod = mv * mdt + 33'sd32768;
    sum  = 22'(mpos) + 22'(prod >>> 16);
    if (sum > 22'(ppu_pkg::POS_MAX)) newpos = ppu_pkg::POS_MAX;
    else if (sum < 22'(ppu_pkg::POS_MIN)) newpos = ppu_pkg::POS_MIN;
    else newpos = sum[19:0];
  end

  always_ff @(posedge clk) begin
    rpx_r   <= px_mem[addr];
    rpy_r   <= py_mem[addr];
    rvx_r   <= vx_mem[addr];
    rvy_r   <= vy_mem[addr];
    rlife_r <= life_mem[addr];
    rapp_r  <= app_mem[addr];
    rlive_r <= live_r[addr];
    if (state_r == S_TMX) nx_r <= newpos;
    if (state_r == S_EMITW) begin
      px_mem[addr]   <= ipx_r;
      py_mem[addr]   <= ipy_r;
      vx_mem[addr]   <= ivx_r;
      vy_mem[addr]   <= ivy_r;
      app_mem[addr]  <= iapp_r;
      life_mem[addr] <= {ilife_r, 8'd0};
    end else if (state_r == S_TMY && rlive_r) begin
      px_mem[addr] <= nx_r;
      py_mem[addr] <= newpos;
      life_mem[addr] <= (rlife_r <= ppu_pkg::life_t'(dt_r)) ? '0
                        : rlife_r - ppu_pkg::life_t'(dt_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    live_cnt_nxt = live_cnt_r;
    live_nxt = live_r;
    full_nxt = full_r;
    mod_nxt = mod_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_nxt = '0;
          cnt_nxt = '0;
          full_nxt = 1'b0;
          mod_nxt = in_slot;
          unique case (in_cmd)
            ppu_pkg::CMD_EMIT:  state_nxt = S_SRCH;
            ppu_pkg::CMD_TICK:  state_nxt = S_TRD;
            ppu_pkg::CMD_READ: begin
              idx_nxt = (32'(in_slot) < 32'(POOL_SIZE)) ? IW'(in_slot) : '0;
              state_nxt = S_RD;
            end
            ppu_pkg::CMD_CLEAR: begin
              live_nxt = '0;
              live_cnt_nxt = '0;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SRCH: begin
        if (!live_r[addr]) state_nxt = S_EMITW;
        else if (idx_r == LAST) begin
          full_nxt = 1'b1;
          state_nxt = S_MOD;
        end else idx_nxt = idx_r + 1'b1;
      end
      // victim slot: reduce the slot field below POOL_SIZE one subtraction a cycle
      S_MOD: begin
        if (11'(mod_r) >= 11'(POOL_SIZE)) mod_nxt = mod_r - 8'(POOL_SIZE);
        else begin
          idx_nxt = IW'(mod_r);
          state_nxt = S_EMITW;
        end
      end
      S_EMITW: begin
        live_nxt[addr] = 1'b1;
        state_nxt = S_DONE;
      end
      S_RD:    state_nxt = S_RDOUT;
      S_RDOUT: state_nxt = S_IDLE;
      S_TRD:   state_nxt = S_TMX;
      S_TMX:   state_nxt = S_TMY;
      S_TMY:   state_nxt = S_TWB;
      S_TWB: begin
        if (rlive_r) begin
          if (rlife_r <= ppu_pkg::life_t'(dt_r)) live_nxt[addr] = 1'b0;
          else if (cnt_r != 9'd511) cnt_nxt = cnt_r + 9'd1;
        end
        if (idx_r == LAST) begin
          live_cnt_nxt = (rlive_r && rlife_r > ppu_pkg::life_t'(dt_r)
                          && cnt_r != 9'd511) ? cnt_r + 9'd1 : cnt_r;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_TRD;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      live_r <= '0;
      live_cnt_r <= '0;
      ov_valid_r <= 1'b0;
      idx_r <= '0;
      cnt_r <= '0;
      full_r <= 1'b0;
      mod_r <= '0;
    end else begin
      state_r <= state_nxt;
      live_r <= live_nxt;
      live_cnt_r <= live_cnt_nxt;
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
      full_r <= full_nxt;
      mod_r <= mod_nxt;
      ov_valid_r <= (state_r == S_DONE) || (state_r == S_RDOUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r <= in_cmd;
      dt_r <= in_dt;
      slot_r <= in_slot;
      ipx_r <= in_pos_x;
      ipy_r <= in_pos_y;
      ivx_r <= in_vel_x;
      ivy_r <= in_vel_y;
      iapp_r <= {in_bg_color, in_fg_color, in_glyph};
      ilife_r <= in_life_span;
    end
    ov_slot_r <= '0; ov_alive_r <= 1'b0; ov_cx_r <= '0; ov_cy_r <= '0;
    ov_gl_r <= '0; ov_fg_r <= '0; ov_bg_r <= '0; ov_repl_r <= 1'b0;
    if (state_r == S_DONE && cmd_r == ppu_pkg::CMD_EMIT) begin
      ov_slot_r <= 8'(idx_r);
      ov_alive_r <= 1'b1;
      ov_cx_r <= ppu_pkg::to_cell(ipx_r);
      ov_cy_r <= ppu_pkg::to_cell(ipy_r);
      ov_gl_r <= iapp_r[7:0];
      ov_fg_r <= iapp_r[15:8];
      ov_bg_r <= iapp_r[23:16];
      ov_repl_r <= full_r;
    end else if (state_r == S_RDOUT) begin
      ov_slot_r <= slot_r;
      if (32'(slot_r) < 32'(POOL_SIZE) && rlive_r) begin
        ov_alive_r <= 1'b1;
        ov_cx_r <= ppu_pkg::to_cell(rpx_r);
        ov_cy_r <= ppu_pkg::to_cell(rpy_r);
        ov_gl_r <= rapp_r[7:0];
        ov_fg_r <= rapp_r[15:8];
        ov_bg_r <= rapp_r[23:16];
      end
    end
  end

  assign out_valid = ov_valid_r;
  assign out_slot_used = ov_slot_r;
  assign out_alive = ov_alive_r;
  assign out_cell_x = ov_cx_r;
  assign out_cell_y = ov_cy_r;
  assign out_glyph_out = ov_gl_r;
  assign out_fg_out = ov_fg_r;
  assign out_bg_out = ov_bg_r;
  assign out_live_count = live_cnt_r;
  assign out_replaced = ov_repl_r;

  `PPU_ASSERT_NXT(a_one_result, clk, rst_n, out_valid, !out_valid)
  `PPU_ASSERT_IMP(a_busy_result, clk, rst_n, out_valid, !busy)
  `PPU_ASSERT_NXT(a_clear_zero, clk, rst_n, state_r == S_IDLE && start && in_cmd == ppu_pkg::CMD_CLEAR, live_r == '0)
  `PPU_ASSERT_IMP(a_repl_alive, clk, rst_n, out_valid && out_replaced, out_alive)
endmodule

FILE: verif/tb_particle_pool_update_core.sv
// Self-checking testbench for particle_pool_update_core: emit, tick, read and clear
// commands are predicted by an in-bench pool model and compared result by result.
// Depends on ppu_pkg and the particle_pool_update_core RTL.
`timescale 1ns / 1ps
module tb_particle_pool_update_core;

  localparam int POOL = 256;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [7:0]         slot_used;
    logic               alive;
    logic signed [11:0] cell_x;
    logic signed [11:0] cell_y;
    logic [7:0]         glyph;
    logic [7:0]         fg;
    logic [7:0]         bg;
    logic [8:0]         live_count;
    logic               replaced;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_cmd = '0;
  logic signed [19:0] in_pos_x = '0, in_pos_y = '0;
  logic signed [15:0] in_vel_x = '0, in_vel_y = '0;
  logic [7:0] in_glyph = '0, in_fg_color = '0, in_bg_color = '0, in_slot = '0;
  logic [15:0] in_life_span = '0, in_dt = '0;
  logic out_valid;
  logic [7:0] out_slot_used, out_glyph_out, out_fg_out, out_bg_out;
  logic out_alive, out_replaced;
  logic signed [11:0] out_cell_x, out_cell_y;
  logic [8:0] out_live_count;

  particle_pool_update_core #(.POOL_SIZE(POOL)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pool shadow
  logic live_q [POOL];
  ppu_pkg::pos_t px_q [POOL], py_q [POOL];
  ppu_pkg::vel_t vx_q [POOL], vy_q [POOL];
  logic [23:0] life_q [POOL];
  logic [7:0] gl_q [POOL], fg_q [POOL], bg_q [POOL];
  logic [8:0] count_q;

  report_t pending_reports[$];
  int errors = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int n_emit = 0, n_tick = 0, n_read = 0, n_clear = 0, n_replaced = 0;

  function automatic logic signed [11:0] cell_of(ppu_pkg::pos_t p);
    int v;
    v = p;
    return 12'(v / 256);
  endfunction

  function automatic ppu_pkg::pos_t step_pos(ppu_pkg::pos_t p, ppu_pkg::vel_t v,
                                             logic [15:0] dt);
    longint prod, st, np;
    prod = longint'(v) * longint'({1'b0, dt}) + 32768;
    st = prod >>> 16;
    np = longint'(p) + st;
    if (np > 524287) np = 524287;
    if (np < -524288) np = -524288;
    return ppu_pkg::pos_t'(np);
  endfunction

  function automatic report_t slot_report(int s);
    report_t r;
    r = '0;
    r.slot_used = 8'(s);
    r.alive = 1'b1;
    r.cell_x = cell_of(px_q[s]);
    r.cell_y = cell_of(py_q[s]);
    r.glyph = gl_q[s];
    r.fg = fg_q[s];
    r.bg = bg_q[s];
    return r;
  endfunction

  function automatic report_t pool_apply(logic [1:0] cmd, ppu_pkg::pos_t x,
                                         ppu_pkg::pos_t y, ppu_pkg::vel_t vx,
                                         ppu_pkg::vel_t vy, logic [7:0] g, logic [7:0] f,
                                         logic [7:0] b, logic [15:0] ls,
                                         logic [15:0] dt, logic [7:0] sl);
    report_t r;
    int s, cnt;
    bit full;
    r = '0;
    case (cmd)
      ppu_pkg::CMD_EMIT: begin
        full = 1;
        s = 0;
        for (int i = 0; i < POOL; i++)
          if (!live_q[i]) begin
            s = i; full = 0; break;
          end
        if (full) s = sl % POOL;
        px_q[s] = x; py_q[s] = y; vx_q[s] = vx; vy_q[s] = vy;
        gl_q[s] = g; fg_q[s] = f; bg_q[s] = b;
        life_q[s] = {ls, 8'd0};
        live_q[s] = 1'b1;
        r = slot_report(s);
        r.replaced = full;
      end
      ppu_pkg::CMD_TICK: begin
        cnt = 0;
        for (int i = 0; i < POOL; i++) begin
          if (!live_q[i]) continue;
          px_q[i] = step_pos(px_q[i], vx_q[i], dt);
          py_q[i] = step_pos(py_q[i], vy_q[i], dt);
          if (life_q[i] <= {8'd0, dt}) begin
            life_q[i] = '0; live_q[i] = 1'b0;
          end else begin
            life_q[i] = life_q[i] - dt;
            if (cnt < 511) cnt++;
          end
        end
        count_q = 9'(cnt);
      end
      ppu_pkg::CMD_READ: begin
        if (sl < POOL && live_q[sl]) r = slot_report(sl);
        r.slot_used = sl;
      end
      default: begin
        for (int i = 0; i < POOL; i++) begin
          live_q[i] = 1'b0; life_q[i] = '0;
        end
        count_q = '0;
      end
    endcase
    r.live_count = count_q;
    return r;
  endfunction

  // start drops only when a real gap follows; a zero gap keeps it high for the next item
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // sends one item, holds it until accepted, and records its expected result
  task automatic send_cmd(logic [1:0] cmd, ppu_pkg::pos_t x = 0, ppu_pkg::pos_t y = 0,
                          ppu_pkg::vel_t vx = 0, ppu_pkg::vel_t vy = 0,
                          logic [7:0] g = 0, logic [7:0] f = 0,
                          logic [7:0] b = 0, logic [15:0] ls = 0,
                          logic [15:0] dt = 0, logic [7:0] sl = 0);
    in_cmd <= cmd; in_pos_x <= x; in_pos_y <= y; in_vel_x <= vx; in_vel_y <= vy;
    in_glyph <= g; in_fg_color <= f; in_bg_color <= b; in_life_span <= ls;
    in_dt <= dt; in_slot <= sl;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_reports.push_back(pool_apply(cmd, x, y, vx, vy, g, f, b, ls, dt, sl));
    case (cmd)
      ppu_pkg::CMD_EMIT: n_emit++;
      ppu_pkg::CMD_TICK: n_tick++;
      ppu_pkg::CMD_READ: n_read++;
      default: n_clear++;
    endcase
    @(negedge clk);
    idle_gap();
  endtask

  task automatic emit_random(bit extreme);
    ppu_pkg::pos_t x, y;
    ppu_pkg::vel_t vx, vy;
    x = ppu_pkg::pos_t'($urandom); y = ppu_pkg::pos_t'($urandom);
    vx = ppu_pkg::vel_t'($urandom); vy = ppu_pkg::vel_t'($urandom);
    if (!extreme) begin
      vx = ppu_pkg::vel_t'($signed($urandom_range(0, 4095)) - 2048);
      vy = ppu_pkg::vel_t'($signed($urandom_range(0, 4095)) - 2048);
    end
    send_cmd(ppu_pkg::CMD_EMIT, x, y, vx, vy, 8'($urandom), 8'($urandom), 8'($urandom),
             16'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 1200)),
             0, 8'($urandom));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    report_t got, want;
    if (rst_n) begin
      if (out_valid) begin
        got = '{out_slot_used, out_alive, out_cell_x, out_cell_y, out_glyph_out,
                out_fg_out, out_bg_out, out_live_count, out_replaced};
        if (pending_reports.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result %p", got);
        end else begin
          want = pending_reports.pop_front();
          if (got !== want) begin
            errors++;
            if (mismatches++ < 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (out_valid || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout, %0d results outstanding", pending_reports.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_cmd(ppu_pkg::CMD_READ, .sl(8'd0));
    send_cmd(ppu_pkg::CMD_TICK, .dt(16'hFFFF));
    send_cmd(ppu_pkg::CMD_EMIT, 20'sh7FFFF, -20'sh80000, 16'sh7FFF, -16'sh8000, 8'hFF,
             8'h00, 8'hFF, 16'hFFFF, 0, 8'd0);
    send_cmd(ppu_pkg::CMD_EMIT, -20'sh80000, 20'sh7FFFF, -16'sh8000, 16'sh7FFF, 8'h00,
             8'hFF, 8'h00, 16'd0, 0, 8'hFF);
    send_cmd(ppu_pkg::CMD_EMIT, -20'sd1, -20'sd256, 16'sd1, -16'sd1, 8'h5A, 8'hA5, 8'h3C,
             16'd1, 0, 0);
    send_cmd(ppu_pkg::CMD_READ, .sl(8'd0));
    send_cmd(ppu_pkg::CMD_READ, .sl(8'd1));
    send_cmd(ppu_pkg::CMD_READ, .sl(8'd2));
    send_cmd(ppu_pkg::CMD_READ, .sl(8'd200));
    send_cmd(ppu_pkg::CMD_TICK, .dt(16'd0));    // zero-life particle dies even with dt 0
    send_cmd(ppu_pkg::CMD_READ, .sl(8'd1));
    send_cmd(ppu_pkg::CMD_TICK, .dt(16'hFFFF)); // saturating moves
    send_cmd(ppu_pkg::CMD_READ, .sl(8'd0));
    send_cmd(ppu_pkg::CMD_READ, .sl(8'd2));
    send_cmd(ppu_pkg::CMD_CLEAR);
    send_cmd(ppu_pkg::CMD_READ, .sl(8'd0));
  endtask

  task automatic test_full_pool();
    send_cmd(ppu_pkg::CMD_CLEAR);
    repeat (POOL) emit_random(0);
    for (int i = 0; i < 10; i++) emit_random(1); // victim given by the slot field
    send_cmd(ppu_pkg::CMD_EMIT, .sl(8'hFF), .ls(16'hFFFF));
    send_cmd(ppu_pkg::CMD_READ, .sl(8'hFF));
    send_cmd(ppu_pkg::CMD_TICK, .dt(16'd100));
    for (int i = 0; i < 20; i++) send_cmd(ppu_pkg::CMD_READ, .sl(8'($urandom)));
  endtask

  task automatic test_random_mix();
    int c;
    for (int n = 0; n < 1000; n++) begin
      c = $urandom_range(0, 99);
      if (c < 45) emit_random($urandom_range(0, 3) == 0);
      else if (c < 55)
        send_cmd(ppu_pkg::CMD_TICK, .dt(16'($urandom_range(0, 4) == 0 ? $urandom :
                                           $urandom_range(0, 600))));
      else if (c < 98)
        send_cmd(ppu_pkg::CMD_READ, .sl(8'($urandom_range(0, 1) ? $urandom :
                                          $urandom_range(0, 40))));
      else send_cmd(ppu_pkg::CMD_CLEAR);
    end
  endtask

  initial begin
    for (int i = 0; i < POOL; i++) begin
      live_q[i] = 0; life_q[i] = 0; px_q[i] = 0; py_q[i] = 0; vx_q[i] = 0; vy_q[i] = 0;
      gl_q[i] = 0; fg_q[i] = 0; bg_q[i] = 0;
    end
    count_q = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_full_pool();
    test_random_mix();
    wait_drained();
    repeat (20) @(negedge clk);
    foreach (pending_reports[i]) errors++;
    $display("covered %0d emits (%0d into a full pool), %0d ticks, %0d reads, %0d clears",
             n_emit, n_replaced, n_tick, n_read, n_clear);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) if (rst_n && out_valid && out_replaced) n_replaced++;
endmodule
